[hw/rtl/replica_exchange_trip_tracker_unit_assert.svh]
// assertion macros for the trip tracker checker
`ifndef REPLICA_EXCHANGE_TRIP_TRACKER_UNIT_ASSERT_SVH
`define REPLICA_EXCHANGE_TRIP_TRACKER_UNIT_ASSERT_SVH

// same-cycle implication
`define RETT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RETT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/rett_pkg.sv]
// types, constants and defaults shared by the trip tracker modules
`default_nettype none

package rett_pkg;

    localparam int DEF_MAX_REPLICAS = 64;
    localparam int DEF_MAX_DIMS     = 2;
    localparam int DEF_COUNT_BITS   = 24;

    localparam int FRAME_W    = 24;
    localparam int IDX_IN_W   = 6;
    localparam int LOC_W      = 2;
    localparam int OUT_W      = 24;
    localparam int S_TDATA_W  = 64;
    localparam int M_TDATA_W  = 120;

    localparam logic [LOC_W-1:0] LOC_BOTTOM = 2'd1;
    localparam logic [LOC_W-1:0] LOC_TOP    = 2'd2;

    typedef enum logic [1:0] {
        TRIP_UNKNOWN = 2'd0,
        TRIP_BOTTOM  = 2'd1,
        TRIP_TOP     = 2'd2
    } trip_st_t;

    typedef enum logic [0:0] {
        ALU_INC_SAT = 1'b0,
        ALU_SUB     = 1'b1
    } alu_op_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_ATT,
        ST_UP,
        ST_DOWN,
        ST_RES,
        ST_TRIP,
        ST_OUT
    } seq_st_t;

    typedef struct packed {
        logic in_ready;
        logic clr_we;
        logic rd_en;
        logic step_att;
        logic step_up;
        logic step_down;
        logic step_res;
        logic step_trip;
        logic out_load;
    } ctrl_t;

endpackage

`default_nettype wire

[hw/rtl/rett_alu.sv]
// shared saturating incrementer and frame subtractor
`default_nettype none

module rett_alu #(
    parameter int COUNT_BITS = rett_pkg::DEF_COUNT_BITS,
    parameter int UW         = 24
) (
    input  rett_pkg::alu_op_t op,
    input  logic [UW-1:0]     a,
    input  logic [UW-1:0]     b,
    output logic [UW-1:0]     y
);
    import rett_pkg::*;

    localparam logic [UW-1:0] CNT_MAX = UW'((64'd1 << COUNT_BITS) - 64'd1);

    logic [UW-1:0] diff;

    assign diff = a - b;

    always_comb begin
        case (op)
            ALU_INC_SAT: y = (a >= CNT_MAX) ? CNT_MAX : a + UW'(1);
            ALU_SUB:     y = UW'(diff[FRAME_W-1:0]);
            default:     y = '0;
        endcase
    end

endmodule

`default_nettype wire

[hw/rtl/rett_ram.sv]
// simple dual-port memory with registered read
`default_nettype none

module rett_ram #(
    parameter int DW = 24,
    parameter int AW = 7
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);
    logic [DW-1:0] mem [2**AW];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[hw/rtl/rett_ctrl.sv]
// sequencer for clearing pass and per-record steps
`default_nettype none

module rett_ctrl #(
    parameter int CLRW = 12
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic              out_free,
    output rett_pkg::ctrl_t   ctrl,
    output logic [CLRW-1:0]   clr_addr
);
    import rett_pkg::*;

    seq_st_t         state_reg, state_next;
    logic [CLRW-1:0] clr_cnt_reg, clr_cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    assign clr_cnt_next = (state_reg == ST_CLEAR) ? clr_cnt_reg + CLRW'(1) : clr_cnt_reg;
    assign clr_addr     = clr_cnt_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: if (&clr_cnt_reg) state_next = ST_IDLE;
            ST_IDLE:  if (s_tvalid) state_next = ST_READ;
            ST_READ:  state_next = ST_ATT;
            ST_ATT:   state_next = ST_UP;
            ST_UP:    state_next = ST_DOWN;
            ST_DOWN:  state_next = ST_RES;
            ST_RES:   state_next = ST_TRIP;
            ST_TRIP:  state_next = ST_OUT;
            ST_OUT:   if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_CLEAR;
        endcase
    end

    always_comb begin
        ctrl = '0;
        case (state_reg)
            ST_CLEAR: ctrl.clr_we    = 1'b1;
            ST_IDLE:  ctrl.in_ready  = 1'b1;
            ST_READ:  ctrl.rd_en     = 1'b1;
            ST_ATT:   ctrl.step_att  = 1'b1;
            ST_UP:    ctrl.step_up   = 1'b1;
            ST_DOWN:  ctrl.step_down = 1'b1;
            ST_RES:   ctrl.step_res  = 1'b1;
            ST_TRIP:  ctrl.step_trip = 1'b1;
            ST_OUT:   ctrl.out_load  = out_free;
            default:  ctrl = '0;
        endcase
    end

endmodule

`default_nettype wire

[hw/rtl/replica_exchange_trip_tracker_unit.sv]
// replica-exchange round-trip tracker, top level
// one record at a time: s_tready stays low while the sequencer steps the record through the
// shared incrementer/subtractor and loads the result, so a new record is taken only after that
// reset: clearing pass over 2**max(2*log2(MAX_REPLICAS), max(1, log2(MAX_DIMS))+log2(MAX_REPLICAS))
// addresses with s_tready low; config writes are taken throughout
`default_nettype none

module replica_exchange_trip_tracker_unit #(
    parameter int MAX_REPLICAS = rett_pkg::DEF_MAX_REPLICAS,
    parameter int MAX_DIMS     = rett_pkg::DEF_MAX_DIMS,
    parameter int COUNT_BITS   = rett_pkg::DEF_COUNT_BITS
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic                             cfg_wr_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // frame_index, replica_slot, replica_index, coord_index, success,
    // partner_index, right_neighbor, location
    input  logic [rett_pkg::S_TDATA_W-1:0]   s_tdata,
    // dimension
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // trip_length, residence_count, attempt_count, accept_up_count, accept_down_count
    output logic [rett_pkg::M_TDATA_W-1:0]   m_tdata,
    // trip_done
    output logic                             m_tuser
);
    import rett_pkg::*;

    localparam int IDXW   = $clog2(MAX_REPLICAS);
    localparam int DIMW   = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int DRW    = DIMW + IDXW;
    localparam int RRW    = 2 * IDXW;
    localparam int CLRW   = (DRW > RRW) ? DRW : RRW;
    localparam int UW     = (COUNT_BITS > FRAME_W) ? COUNT_BITS : FRAME_W;
    localparam int IN_IDX_N = 2 ** IDX_IN_W;

    typedef logic [IDXW-1:0] idx_tab_t [IN_IDX_N];

    function automatic idx_tab_t build_idx_tab();
        idx_tab_t t;
        int       r;
        r = 0;
        for (int i = 0; i < IN_IDX_N; i++) begin
            t[i] = IDXW'(r);
            r = (r == MAX_REPLICAS - 1) ? 0 : r + 1;
        end
        return t;
    endfunction

    localparam idx_tab_t IDX_TAB = build_idx_tab();

    function automatic logic [OUT_W-1:0] to_out(input logic [COUNT_BITS-1:0] v);
        logic [UW-1:0] w;
        w = UW'(v);
        return w[OUT_W-1:0];
    endfunction

    ctrl_t            ctrl;
    logic [CLRW-1:0]  clr_addr;
    logic             out_free;

    logic             stats_reg;
    logic [COUNT_BITS-1:0] att_reg [MAX_DIMS];

    logic [FRAME_W-1:0] frame_reg;
    logic [IDXW-1:0]    slot_reg, rep_reg, crd_reg;
    logic [DIMW-1:0]    dim_reg, dim_in;
    logic               succ_reg, updir_reg;
    logic [LOC_W-1:0]   loc_reg;

    logic [COUNT_BITS-1:0] up_rd, down_rd, res_rd;
    logic [1:0]            trip_rd;
    logic [FRAME_W-1:0]    bframe_rd;

    alu_op_t         alu_op;
    logic [UW-1:0]   alu_a, alu_b, alu_y;

    logic [COUNT_BITS-1:0] r_att_reg, r_up_reg, r_down_reg, r_res_reg;
    logic                  r_done_reg;
    logic [FRAME_W-1:0]    r_len_reg;

    logic                  m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]  m_tdata_reg;
    logic                  m_tuser_reg;

    logic [DRW-1:0]  ds_addr, ct_addr;
    logic [RRW-1:0]  rc_addr;
    logic            up_we, down_we, res_we, trip_we, bframe_we;
    logic            set_bottom, set_top, trip_end, slot_zero;
    logic [1:0]      trip_wdata;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = ctrl.in_ready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    rett_ctrl #(.CLRW(CLRW)) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .out_free (out_free),
        .ctrl     (ctrl),
        .clr_addr (clr_addr)
    );

    // input capture
    assign dim_in = (MAX_DIMS == 1) ? '0 : DIMW'(s_tuser);

    always_ff @(posedge aclk) begin
        if (s_tvalid && ctrl.in_ready) begin
            frame_reg <= s_tdata[23:0];
            slot_reg  <= IDX_TAB[s_tdata[29:24]];
            rep_reg   <= IDX_TAB[s_tdata[35:30]];
            crd_reg   <= IDX_TAB[s_tdata[41:36]];
            dim_reg   <= dim_in;
            succ_reg  <= s_tdata[42];
            updir_reg <= (s_tdata[48:43] == s_tdata[54:49]);
            loc_reg   <= s_tdata[56:55];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stats_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            stats_reg <= cfg_wr_data;
        end
    end

    // shared unit operands
    always_comb begin
        alu_op = ALU_INC_SAT;
        alu_b  = '0;
        alu_a  = UW'(att_reg[dim_reg]);
        if (ctrl.step_up) begin
            alu_a = UW'(up_rd);
        end else if (ctrl.step_down) begin
            alu_a = UW'(down_rd);
        end else if (ctrl.step_res) begin
            alu_a = UW'(res_rd);
        end else if (ctrl.step_trip) begin
            alu_op = ALU_SUB;
            alu_a  = UW'(frame_reg);
            alu_b  = UW'(bframe_rd);
        end
    end

    rett_alu #(.COUNT_BITS(COUNT_BITS), .UW(UW)) u_alu (
        .op (alu_op),
        .a  (alu_a),
        .b  (alu_b),
        .y  (alu_y)
    );

    // addresses and write enables
    assign ds_addr = {dim_reg, slot_reg};
    assign ct_addr = {dim_reg, crd_reg};
    assign rc_addr = {rep_reg, crd_reg};

    assign slot_zero  = (slot_reg == '0);
    assign set_bottom = (loc_reg == LOC_BOTTOM) && (trip_rd != TRIP_BOTTOM);
    assign set_top    = (loc_reg == LOC_TOP) && (trip_rd == TRIP_BOTTOM);
    assign trip_end   = (loc_reg == LOC_BOTTOM) && (trip_rd != TRIP_BOTTOM)
                        && (trip_rd != TRIP_UNKNOWN);

    assign up_we     = ctrl.step_up && succ_reg && updir_reg;
    assign down_we   = ctrl.step_down && succ_reg && !updir_reg;
    assign res_we    = ctrl.step_res && stats_reg;
    assign bframe_we = ctrl.step_trip && stats_reg && set_bottom;
    assign trip_we   = ctrl.clr_we || (ctrl.step_trip && stats_reg && (set_bottom || set_top));
    assign trip_wdata = ctrl.clr_we ? TRIP_UNKNOWN : (set_top ? TRIP_TOP : TRIP_BOTTOM);

    rett_ram #(.DW(COUNT_BITS), .AW(DRW)) u_up_ram (
        .aclk  (aclk),
        .we    (ctrl.clr_we || up_we),
        .waddr (ctrl.clr_we ? clr_addr[DRW-1:0] : ds_addr),
        .wdata (ctrl.clr_we ? '0 : alu_y[COUNT_BITS-1:0]),
        .re    (ctrl.rd_en),
        .raddr (ds_addr),
        .rdata (up_rd)
    );

    rett_ram #(.DW(COUNT_BITS), .AW(DRW)) u_down_ram (
        .aclk  (aclk),
        .we    (ctrl.clr_we || down_we),
        .waddr (ctrl.clr_we ? clr_addr[DRW-1:0] : ds_addr),
        .wdata (ctrl.clr_we ? '0 : alu_y[COUNT_BITS-1:0]),
        .re    (ctrl.rd_en),
        .raddr (ds_addr),
        .rdata (down_rd)
    );

    rett_ram #(.DW(COUNT_BITS), .AW(RRW)) u_res_ram (
        .aclk  (aclk),
        .we    (ctrl.clr_we || res_we),
        .waddr (ctrl.clr_we ? clr_addr[RRW-1:0] : rc_addr),
        .wdata (ctrl.clr_we ? '0 : alu_y[COUNT_BITS-1:0]),
        .re    (ctrl.rd_en),
        .raddr (rc_addr),
        .rdata (res_rd)
    );

    rett_ram #(.DW(2), .AW(DRW)) u_trip_ram (
        .aclk  (aclk),
        .we    (trip_we),
        .waddr (ctrl.clr_we ? clr_addr[DRW-1:0] : ct_addr),
        .wdata (trip_wdata),
        .re    (ctrl.rd_en),
        .raddr (ct_addr),
        .rdata (trip_rd)
    );

    rett_ram #(.DW(FRAME_W), .AW(DRW)) u_bframe_ram (
        .aclk  (aclk),
        .we    (bframe_we),
        .waddr (ct_addr),
        .wdata (frame_reg),
        .re    (ctrl.rd_en),
        .raddr (ct_addr),
        .rdata (bframe_rd)
    );

    // attempt counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int d = 0; d < MAX_DIMS; d++) begin
                att_reg[d] <= '0;
            end
        end else if (ctrl.step_att && slot_zero) begin
            att_reg[dim_reg] <= alu_y[COUNT_BITS-1:0];
        end
    end

    // result collection
    always_ff @(posedge aclk) begin
        if (ctrl.step_att) begin
            r_att_reg <= slot_zero ? alu_y[COUNT_BITS-1:0] : att_reg[dim_reg];
        end
        if (ctrl.step_up) begin
            r_up_reg <= up_we ? alu_y[COUNT_BITS-1:0] : up_rd;
        end
        if (ctrl.step_down) begin
            r_down_reg <= down_we ? alu_y[COUNT_BITS-1:0] : down_rd;
        end
        if (ctrl.step_res) begin
            r_res_reg <= res_we ? alu_y[COUNT_BITS-1:0] : res_rd;
        end
        if (ctrl.step_trip) begin
            r_done_reg <= stats_reg && trip_end;
            r_len_reg  <= (stats_reg && trip_end) ? alu_y[FRAME_W-1:0] : '0;
        end
    end

    // output register
    assign m_tvalid_next = ctrl.out_load ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.out_load) begin
            m_tdata_reg <= {to_out(r_down_reg), to_out(r_up_reg), to_out(r_att_reg),
                            to_out(r_res_reg), r_len_reg};
            m_tuser_reg <= r_done_reg;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/rett_checker.sv]
// port-level checker for the trip tracker, bound to the top level
`default_nettype none

`include "replica_exchange_trip_tracker_unit_assert.svh"

module rett_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [rett_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic                           m_tuser
);

    `RETT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled beat changed")

    `RETT_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready again straight after a beat")

    `RETT_ASSERT_NEXT(a_no_instant_result, s_tvalid && s_tready && !m_tvalid, !m_tvalid, "result appeared one cycle after accept")

    `RETT_ASSERT_NOW(a_len_zero_no_trip, m_tvalid && !m_tuser, m_tdata[23:0] == 24'd0, "trip length without completed trip")

endmodule

bind replica_exchange_trip_tracker_unit rett_checker u_rett_checker (.*);

`default_nettype wire
